// ===== hdl/bsha1_pkg.sv =====
// ----------------------------------------------------------------------------
// bsha1_pkg
// Types, constants and round functions shared by the broken SHA-1 digest.
// ----------------------------------------------------------------------------
`default_nettype none

package bsha1_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 80;
  localparam int CHAIN_LEN   = 5;

  typedef logic [31:0] word_t;
  typedef logic [CHAIN_LEN-1:0][31:0] chain_t;
  typedef logic [6:0] rnd_t;
  typedef logic [5:0] bpos_t;
  typedef logic [2:0] widx_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hefcdab89;
  localparam word_t IV2 = 32'h98badcfe;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hc3d2e1f0;
  localparam chain_t CHAIN_IV = {IV4, IV3, IV2, IV1, IV0};

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h0 - 32'h70e44324;
  localparam word_t K3 = 32'h0 - 32'h359d3e2a;

  localparam rnd_t LAST_ROUND = rnd_t'(ROUNDS - 1);
  localparam widx_t LAST_WORD = widx_t'(CHAIN_LEN - 1);

  typedef struct packed {
    logic  wr;
    logic  shift;
    logic  clear;
    bpos_t pos;
    logic [7:0] data;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic reinit;
    rnd_t rnd;
  } round_ctrl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {x, x} << n;
    return tmp[63:32];
  endfunction

  function automatic word_t round_k(input rnd_t t);
    word_t k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic word_t round_f(input rnd_t t, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t >= 7'd40 && t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bsha1_if.sv =====
// ----------------------------------------------------------------------------
// bsha1 channel interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bsha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

// ===== hdl/bsha1_sched.sv =====
// ----------------------------------------------------------------------------
// bsha1_sched
// Message block window: packs bytes into words and produces one schedule
// word per round by shifting a sixteen-word window.
// ----------------------------------------------------------------------------
`default_nettype none

module bsha1_sched
  import bsha1_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  sched_ctrl_t ctrl,
  output word_t       w_cur
);

  word_t win_r [BLOCK_WORDS];
  word_t acc_r;
  word_t word_nxt;
  word_t w_new;

  assign word_nxt = ((ctrl.pos[1:0] == 2'd0) ? '0 : acc_r)
                    | (word_t'(ctrl.data) << {ctrl.pos[1:0], 3'b000});
  assign w_new = rotl(32'd1, 5'(win_r[0] ^ win_r[2] ^ win_r[8] ^ win_r[13]));
  assign w_cur = win_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctrl.shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BLOCK_WORDS-1] <= w_new;
    end else if (ctrl.wr) begin
      win_r[ctrl.pos[5:2]] <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      acc_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsha1_round.sv =====
// ----------------------------------------------------------------------------
// bsha1_round
// Shared compression round unit with its working variables and the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bsha1_round
  import bsha1_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  round_ctrl_t ctrl,
  input  word_t       w_cur,
  output chain_t      chain
);

  word_t  a_r, b_r, c_r, d_r, e_r;
  chain_t chain_r;
  word_t  a_nxt;

  assign a_nxt = rotl(a_r, 5'd5) + round_f(ctrl.rnd, b_r, c_r, d_r) + e_r
                 + round_k(ctrl.rnd) + w_cur;
  assign chain = chain_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctrl.step) begin
      a_r <= a_nxt;
      b_r <= a_r;
      c_r <= rotl(b_r, 5'd30);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.reinit) begin
      chain_r <= CHAIN_IV;
    end else if (ctrl.fold) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/broken_sha1_digest.sv =====
// ----------------------------------------------------------------------------
// broken_sha1_digest
// Broken SHA-1 (XSHA1) digest of a byte stream, one byte per transaction.
//
// The input channel takes one message byte per transaction, with final_byte
// marking the last byte of a message. Bytes are packed little-endian into a
// sixteen-word block. The 64th byte of a block, or a final byte, starts a
// compression that runs one round per cycle through the shared round unit:
// a load step, 80 rounds and a fold step, during which in_ch.ready is low.
// After a final byte, the five digest words leave on the output channel as
// five transactions, word_index 0 first, last_word set on the fifth. When the
// receiver stalls, the current word holds and no new byte is taken until
// the fifth word is accepted; the chain then returns to the initial vector.
// Reset (synchronous, active low) clears the block and the byte position
// and loads the initial vector.
// ----------------------------------------------------------------------------
`default_nettype none

module broken_sha1_digest
  import bsha1_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  bsha1_in_if.sink     in_ch,
  bsha1_out_if.source  out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  bpos_t       pos_r, pos_nxt;
  rnd_t        rnd_r, rnd_nxt;
  logic        last_r, last_nxt;
  widx_t       idx_r, idx_nxt;
  logic        in_acc;
  logic        out_acc;
  sched_ctrl_t sctrl;
  round_ctrl_t rctrl;
  word_t       w_cur;
  chain_t      chain;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign out_ch.digest_word = chain[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == LAST_WORD);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    sctrl.wr    = 1'b0;
    sctrl.shift = 1'b0;
    sctrl.clear = 1'b0;
    sctrl.pos   = pos_r;
    sctrl.data  = in_ch.data_byte;
    rctrl.load   = 1'b0;
    rctrl.step   = 1'b0;
    rctrl.fold   = 1'b0;
    rctrl.reinit = 1'b0;
    rctrl.rnd    = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sctrl.wr = 1'b1;
          pos_nxt  = pos_r + 6'd1;
          last_nxt = in_ch.final_byte;
          if (in_ch.final_byte || pos_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        rctrl.load = 1'b1;
        rnd_nxt    = '0;
        state_nxt  = ST_RND;
      end
      ST_RND: begin
        rctrl.step  = 1'b1;
        sctrl.shift = 1'b1;
        rnd_nxt     = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        rctrl.fold  = 1'b1;
        sctrl.clear = 1'b1;
        pos_nxt     = '0;
        idx_nxt     = '0;
        state_nxt   = last_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            rctrl.reinit = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      last_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      last_r  <= last_nxt;
      idx_r   <= idx_nxt;
    end
  end

  bsha1_sched u_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (sctrl),
    .w_cur (w_cur)
  );

  bsha1_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (rctrl),
    .w_cur (w_cur),
    .chain (chain)
  );

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("Input taken while a digest word is pending.");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.final_byte) |=> !in_ch.ready)
    else $error("Input ready right after a final byte.");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (rnd_r <= LAST_ROUND))
    else $error("Round counter out of range.");

  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (idx_r <= LAST_WORD))
    else $error("Digest word index out of range.");

  a_word_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_ch.last_word) |=> (out_ch.valid
      && out_ch.word_index == $past(out_ch.word_index) + 3'd1))
    else $error("Digest words not delivered in order.");
`endif

endmodule

`default_nettype wire
